// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker modules.
// Needs a clk and rst signal in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== rtl/core/srbu_pkg.sv =====
// Shared types and constants for the row bitmap union unit.
// No dependencies.
`default_nettype none
package srbu_pkg;
  localparam int COLS_DEFAULT = 65536;
  localparam int COL_W        = 16;
  localparam int NNZ_W        = 17;
  localparam int MAP_MAX      = 65536;
  localparam int QDEPTH       = 2;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             is_col;
    logic             last;
  } op_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;
endpackage
`default_nettype wire

// ===== rtl/core/srbu_front.sv =====
// Front end: accepts input transfers, classifies them and queues operations.
// Depends on srbu_pkg.
`default_nettype none
module srbu_front #(
  parameter int COLS = srbu_pkg::COLS_DEFAULT
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire [srbu_pkg::COL_W-1:0]     col_index,
  input  wire                           has_col,
  input  wire                           row_end,
  input  srbu_pkg::back_status_t        status,
  output logic                          q_valid,
  input  wire                           q_pop,
  output srbu_pkg::op_t                 q_data
);
  localparam int PW = $clog2(srbu_pkg::QDEPTH);
  localparam int CW = $clog2(srbu_pkg::QDEPTH + 1);

  srbu_pkg::op_t q_mem [srbu_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          col_ok;
  srbu_pkg::op_t op_in;
  logic          push;
  logic          pop;

  always_comb begin
    col_ok       = (32'(col_index) < 32'(COLS));
    op_in.col    = col_index;
    op_in.is_col = has_col && col_ok;
    op_in.last   = row_end;
    in_ready     = !status.init_busy && (count != CW'(srbu_pkg::QDEPTH));
    push         = in_valid && in_ready && (op_in.is_col || op_in.last);
    q_valid      = (count != '0);
    pop          = q_pop && q_valid;
    q_data       = q_mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/srbu_back.sv =====
// Back end: seen bitmap and emitted list memories, lookup sequencer,
// row-end clear walk and output register. Depends on srbu_pkg.
`default_nettype none
module srbu_back #(
  parameter int COLS = srbu_pkg::COLS_DEFAULT
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           q_valid,
  output logic                          q_pop,
  input  srbu_pkg::op_t                 q_data,
  output srbu_pkg::back_status_t        status,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [srbu_pkg::COL_W-1:0]    col_out,
  output logic                          col_valid,
  output logic                          row_last,
  output logic [srbu_pkg::NNZ_W-1:0]    row_nnz
);
  localparam int MAP_DEPTH = (COLS > srbu_pkg::MAP_MAX) ? srbu_pkg::MAP_MAX : COLS;
  localparam int AW        = $clog2(MAP_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_DEPTH - 1);

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_CLR  = 3'd3;

  logic                          seen_mem [MAP_DEPTH];
  logic [srbu_pkg::COL_W-1:0]    list_mem [MAP_DEPTH];

  logic [2:0]                    state;
  logic [2:0]                    state_next;
  logic [AW-1:0]                 init_addr;
  srbu_pkg::op_t                 cur;
  logic [srbu_pkg::NNZ_W-1:0]    cnt;
  logic [srbu_pkg::NNZ_W-1:0]    clr_k;
  logic                          clr_pend;
  logic                          seen_rd;
  logic [srbu_pkg::COL_W-1:0]    list_rd;

  logic                          seen_we;
  logic [AW-1:0]                 seen_wa;
  logic                          seen_wd;
  logic                          seen_re;
  logic [AW-1:0]                 seen_ra;
  logic                          list_we;
  logic [AW-1:0]                 list_wa;
  logic                          list_re;
  logic [AW-1:0]                 list_ra;
  logic                          fresh;
  logic                          emit;
  logic                          clr_done;

  always_comb begin
    seen_we    = 1'b0;
    seen_wa    = init_addr;
    seen_wd    = 1'b0;
    seen_re    = 1'b0;
    seen_ra    = q_data.col[AW-1:0];
    list_we    = 1'b0;
    list_wa    = cnt[AW-1:0];
    list_re    = 1'b0;
    list_ra    = clr_k[AW-1:0];
    q_pop      = 1'b0;
    fresh      = cur.is_col && !seen_rd;
    emit       = 1'b0;
    clr_done   = 1'b0;
    state_next = state;
    case (state)
      ST_INIT: begin
        seen_we = 1'b1;
        if (init_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid && (!out_valid || out_ready)) begin
          q_pop      = 1'b1;
          seen_re    = 1'b1;
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        emit = fresh || cur.last;
        if (fresh) begin
          seen_we = 1'b1;
          seen_wa = cur.col[AW-1:0];
          seen_wd = 1'b1;
          list_we = 1'b1;
        end
        state_next = cur.last ? ST_CLR : ST_IDLE;
      end
      ST_CLR: begin
        list_re = (clr_k != cnt);
        if (clr_pend) begin
          seen_we = 1'b1;
          seen_wa = list_rd[AW-1:0];
        end
        if (clr_k == cnt && !clr_pend) begin
          clr_done   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
    status.init_busy = (state == ST_INIT);
  end

  always_ff @(posedge clk) begin
    if (seen_we) begin
      seen_mem[seen_wa] <= seen_wd;
    end
    if (seen_re) begin
      seen_rd <= seen_mem[seen_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[list_wa] <= cur.col;
    end
    if (list_re) begin
      list_rd <= list_mem[list_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (emit) begin
      col_out   <= fresh ? cur.col : '0;
      col_valid <= fresh;
      row_last  <= cur.last;
      row_nnz   <= cur.last ? (cnt + srbu_pkg::NNZ_W'(fresh)) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      init_addr <= '0;
      cnt       <= '0;
      clr_k     <= '0;
      clr_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      clr_pend <= list_re;
      if (state == ST_INIT) begin
        init_addr <= init_addr + 1'b1;
      end
      if (state == ST_CHK) begin
        cnt   <= cnt + srbu_pkg::NNZ_W'(fresh);
        clr_k <= '0;
      end else if (clr_done) begin
        cnt <= '0;
      end
      if (list_re) begin
        clr_k <= clr_k + 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/spgemm_row_bitmap_union_unit.sv =====
// Path: input queue, seen-bitmap read in the idle state, check state, output register.
// The back end pops a new input only after the read/check/write loop for the last one.
// Each row end adds a clear walk that zeroes the seen bit of every listed column.
// Reset: synchronous; afterwards the bitmap is zeroed one entry per cycle, all
// min(COLS, 65536) entries, while in_ready stays low.
// Top level; instantiates srbu_front and srbu_back, uses srbu_pkg.
`default_nettype none
module spgemm_row_bitmap_union_unit #(
  parameter int COLS = srbu_pkg::COLS_DEFAULT
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire [srbu_pkg::COL_W-1:0]     col_index,
  input  wire                           has_col,
  input  wire                           row_end,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [srbu_pkg::COL_W-1:0]    col_out,
  output logic                          col_valid,
  output logic                          row_last,
  output logic [srbu_pkg::NNZ_W-1:0]    row_nnz
);
  srbu_pkg::back_status_t status;
  srbu_pkg::op_t          q_data;
  logic                   q_valid;
  logic                   q_pop;

  srbu_front #(.COLS(COLS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .col_index (col_index),
    .has_col   (has_col),
    .row_end   (row_end),
    .status    (status),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data)
  );

  srbu_back #(.COLS(COLS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .col_out   (col_out),
    .col_valid (col_valid),
    .row_last  (row_last),
    .row_nnz   (row_nnz)
  );
endmodule
`default_nettype wire

// ===== rtl/core/srbu_checker.sv =====
// Port-level checks for the row bitmap union unit, bound to the top level.
// Depends on assert_macros.svh and srbu_pkg.
`default_nettype none
`include "assert_macros.svh"
module srbu_checker (
  input wire                           clk,
  input wire                           rst,
  input wire                           out_valid,
  input wire                           out_ready,
  input wire [srbu_pkg::COL_W-1:0]     col_out,
  input wire                           col_valid,
  input wire                           row_last,
  input wire [srbu_pkg::NNZ_W-1:0]     row_nnz
);
  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(col_out) && $stable(row_nnz))
  `CHK_IMPL(a_col_zero, out_valid && !col_valid, col_out == '0)
  `CHK_IMPL(a_nnz_zero, out_valid && !row_last, row_nnz == '0)
  `CHK_IMPL(a_has_cause, out_valid, col_valid || row_last)
  `CHK_IMPL(a_nnz_counts, out_valid && row_last && col_valid, row_nnz != '0)
endmodule

bind spgemm_row_bitmap_union_unit srbu_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .col_out   (col_out),
  .col_valid (col_valid),
  .row_last  (row_last),
  .row_nnz   (row_nnz)
);
`default_nettype wire
